@@ rtl/lfsub_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lfsub_pkg
// Shared constants, command and status types for the subtractive lagged
// Fibonacci generator.
// ----------------------------------------------------------------------------
package lfsub_pkg;

	localparam int LONG_LAG      = 100;
	localparam int SHORT_LAG     = 37;
	localparam int BATCH_LEN_DEF = 1009;
	localparam int SCR_DEPTH     = 2 * LONG_LAG - 1;
	localparam int WORD_W        = 30;
	localparam int RING_AW       = 7;
	localparam int SCR_AW        = 8;
	localparam int CNT_W         = 11;
	localparam int WARM_STEPS    = 10 * SCR_DEPTH;
	localparam int SQ_ROUNDS     = 'h45;
	localparam int DRAW_WORDS    = 4;

	localparam logic [WORD_W-1:0] ZERO_SEED   = 30'h4CB2F;
	localparam logic [WORD_W-1:0] LADDER_MASK = 30'h3FFFFFFE;
	localparam logic [WORD_W:0]   LADDER_SUB  = 31'h3FFFFFFE;

	typedef logic [1:0] wsel_t;
	localparam wsel_t WS_LADDER = 2'd0;
	localparam wsel_t WS_RDATA  = 2'd1;
	localparam wsel_t WS_ZERO   = 2'd2;
	localparam wsel_t WS_SUB    = 2'd3;

	typedef struct packed {
		logic               seed_load;
		logic               ld_step;
		logic               ld_odd;
		logic               sq_shift;
		logic               sc_re;
		logic [SCR_AW-1:0]  sc_raddr;
		logic               sc_we;
		logic [SCR_AW-1:0]  sc_waddr;
		wsel_t              sc_wsel;
		logic               hold_ld;
		logic               ring_step;
		logic               ring_copy;
		logic [RING_AW-1:0] copy_idx;
		logic               ring_ld_we;
		logic [RING_AW-1:0] ring_lidx;
		logic               rd_reset;
		logic               batch_re;
		logic               out_load;
	} cmd_t;

	typedef struct packed {
		logic rd_zero;
		logic sq_zero;
		logic sq_lsb;
	} stat_t;

endpackage
`default_nettype wire

@@ rtl/lfsub_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lfsub_ctrl
// Sequencer: seeding passes over the scratch memory, ring warm-up and batch
// regeneration, draw reads and the output handshake.
// ----------------------------------------------------------------------------
module lfsub_ctrl #(
	parameter int BATCH_LENGTH = lfsub_pkg::BATCH_LEN_DEF
) (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic in_valid,
	output                     logic in_ready,
	input  wire                logic mode,
	input  wire                logic out_ready,
	output                     logic out_valid,
	output lfsub_pkg::cmd_t    cmd,
	input  lfsub_pkg::stat_t   stat
);
	import lfsub_pkg::*;

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_LADDER  = 5'd1;
	localparam logic [4:0] S_DBL_R   = 5'd2;
	localparam logic [4:0] S_DBL_W1  = 5'd3;
	localparam logic [4:0] S_DBL_W0  = 5'd4;
	localparam logic [4:0] S_RED0    = 5'd5;
	localparam logic [4:0] S_RED1    = 5'd6;
	localparam logic [4:0] S_RED2    = 5'd7;
	localparam logic [4:0] S_RED3    = 5'd8;
	localparam logic [4:0] S_SH_R    = 5'd9;
	localparam logic [4:0] S_SH_W    = 5'd10;
	localparam logic [4:0] S_SH_A    = 5'd11;
	localparam logic [4:0] S_SH_B    = 5'd12;
	localparam logic [4:0] S_SH_C    = 5'd13;
	localparam logic [4:0] S_RND_END = 5'd14;
	localparam logic [4:0] S_LOAD_R  = 5'd15;
	localparam logic [4:0] S_LOAD_W  = 5'd16;
	localparam logic [4:0] S_WARM    = 5'd17;
	localparam logic [4:0] S_REGEN   = 5'd18;
	localparam logic [4:0] S_RD      = 5'd19;
	localparam logic [4:0] S_OUT     = 5'd20;

	localparam logic [SCR_AW-1:0] TOP_IDX  = SCR_AW'(SCR_DEPTH - 1);
	localparam logic [SCR_AW-1:0] LAG_IDX  = SCR_AW'(LONG_LAG);
	localparam logic [SCR_AW-1:0] LAST_IDX = SCR_AW'(LONG_LAG - 1);
	localparam logic [SCR_AW-1:0] SHORT_IDX = SCR_AW'(SHORT_LAG);
	localparam logic [SCR_AW-1:0] DIFF_IDX = SCR_AW'(LONG_LAG - SHORT_LAG);

	logic [4:0]        state_q, state_d;
	logic [SCR_AW-1:0] j_q, j_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [6:0]        t_q, t_d;
	logic              out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		j_d     = j_q;
		cnt_d   = cnt_q;
		t_d     = t_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cnt_d = '0;
					if (mode) begin
						cmd.seed_load = 1'b1;
						cmd.rd_reset  = 1'b1;
						state_d       = S_LADDER;
					end else if (stat.rd_zero) begin
						state_d = S_REGEN;
					end else begin
						state_d = S_RD;
					end
				end
			end
			S_LADDER: begin
				cmd.sc_we    = 1'b1;
				cmd.sc_waddr = cnt_q[SCR_AW-1:0];
				cmd.sc_wsel  = WS_LADDER;
				cmd.ld_odd   = (cnt_q == CNT_W'(1));
				cmd.ld_step  = 1'b1;
				if (cnt_q == CNT_W'(LONG_LAG - 1)) begin
					t_d     = 7'(SQ_ROUNDS);
					j_d     = LAST_IDX;
					state_d = S_DBL_R;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_DBL_R: begin
				cmd.sc_re    = 1'b1;
				cmd.sc_raddr = j_q;
				state_d      = S_DBL_W1;
			end
			S_DBL_W1: begin
				cmd.sc_we    = 1'b1;
				cmd.sc_waddr = {j_q[SCR_AW-2:0], 1'b0};
				cmd.sc_wsel  = WS_RDATA;
				state_d      = S_DBL_W0;
			end
			S_DBL_W0: begin
				cmd.sc_we    = 1'b1;
				cmd.sc_waddr = {j_q[SCR_AW-2:0], 1'b0} - 1'b1;
				cmd.sc_wsel  = WS_ZERO;
				if (j_q == SCR_AW'(1)) begin
					j_d     = TOP_IDX;
					state_d = S_RED0;
				end else begin
					j_d     = j_q - 1'b1;
					state_d = S_DBL_R;
				end
			end
			S_RED0: begin
				cmd.sc_re    = 1'b1;
				cmd.sc_raddr = j_q;
				state_d      = S_RED1;
			end
			S_RED1: begin
				cmd.hold_ld  = 1'b1;
				cmd.sc_re    = 1'b1;
				cmd.sc_raddr = j_q - DIFF_IDX;
				state_d      = S_RED2;
			end
			S_RED2: begin
				cmd.sc_we    = 1'b1;
				cmd.sc_waddr = j_q - DIFF_IDX;
				cmd.sc_wsel  = WS_SUB;
				cmd.sc_re    = 1'b1;
				cmd.sc_raddr = j_q - LAG_IDX;
				state_d      = S_RED3;
			end
			S_RED3: begin
				cmd.sc_we    = 1'b1;
				cmd.sc_waddr = j_q - LAG_IDX;
				cmd.sc_wsel  = WS_SUB;
				if (j_q == LAG_IDX) begin
					if (stat.sq_lsb) begin
						j_d     = LAG_IDX;
						state_d = S_SH_R;
					end else begin
						state_d = S_RND_END;
					end
				end else begin
					j_d     = j_q - 1'b1;
					state_d = S_RED0;
				end
			end
			S_SH_R: begin
				cmd.sc_re    = 1'b1;
				cmd.sc_raddr = j_q - 1'b1;
				state_d      = S_SH_W;
			end
			S_SH_W: begin
				cmd.sc_we    = 1'b1;
				cmd.sc_waddr = j_q;
				cmd.sc_wsel  = WS_RDATA;
				if (j_q == SCR_AW'(1)) begin
					state_d = S_SH_A;
				end else begin
					j_d     = j_q - 1'b1;
					state_d = S_SH_R;
				end
			end
			S_SH_A: begin
				cmd.sc_re    = 1'b1;
				cmd.sc_raddr = LAG_IDX;
				state_d      = S_SH_B;
			end
			S_SH_B: begin
				cmd.hold_ld  = 1'b1;
				cmd.sc_we    = 1'b1;
				cmd.sc_waddr = '0;
				cmd.sc_wsel  = WS_RDATA;
				cmd.sc_re    = 1'b1;
				cmd.sc_raddr = SHORT_IDX;
				state_d      = S_SH_C;
			end
			S_SH_C: begin
				cmd.sc_we    = 1'b1;
				cmd.sc_waddr = SHORT_IDX;
				cmd.sc_wsel  = WS_SUB;
				state_d      = S_RND_END;
			end
			S_RND_END: begin
				// Rounds keep going while seed bits remain, then a fixed count more.
				if (!stat.sq_zero) begin
					cmd.sq_shift = 1'b1;
					j_d          = LAST_IDX;
					state_d      = S_DBL_R;
				end else if (t_q == 7'd1) begin
					j_d     = '0;
					state_d = S_LOAD_R;
				end else begin
					t_d     = t_q - 1'b1;
					j_d     = LAST_IDX;
					state_d = S_DBL_R;
				end
			end
			S_LOAD_R: begin
				cmd.sc_re    = 1'b1;
				cmd.sc_raddr = j_q;
				state_d      = S_LOAD_W;
			end
			S_LOAD_W: begin
				cmd.ring_ld_we = 1'b1;
				cmd.ring_lidx  = (j_q < SHORT_IDX) ? RING_AW'(j_q + DIFF_IDX)
				                                   : RING_AW'(j_q - SHORT_IDX);
				if (j_q == LAST_IDX) begin
					cnt_d   = '0;
					state_d = S_WARM;
				end else begin
					j_d     = j_q + 1'b1;
					state_d = S_LOAD_R;
				end
			end
			S_WARM: begin
				cmd.ring_step = 1'b1;
				if (cnt_q == CNT_W'(WARM_STEPS - 1)) begin
					state_d = S_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_REGEN: begin
				// The first ring-length steps read the old ring, which is the batch.
				cmd.ring_step = 1'b1;
				cmd.ring_copy = (cnt_q < CNT_W'(LONG_LAG));
				cmd.copy_idx  = cnt_q[RING_AW-1:0];
				if (cnt_q == CNT_W'(BATCH_LENGTH - 1)) begin
					cnt_d   = '0;
					state_d = S_RD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_RD: begin
				cmd.batch_re = 1'b1;
				if (cnt_q == CNT_W'(DRAW_WORDS - 1)) begin
					state_d = S_OUT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			j_q         <= '0;
			cnt_q       <= '0;
			t_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			j_q     <= j_d;
			cnt_q   <= cnt_d;
			t_q     <= t_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/lfsub_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lfsub_dp
// Datapath: lag ring with its recurrence pipeline, output batch, seeding
// scratch memory, seed registers and the draw combiner.
// ----------------------------------------------------------------------------
module lfsub_dp (
	input  wire              logic        clk,
	input  wire              logic        arst_n,
	input  wire              logic [63:0] seed_value,
	input  lfsub_pkg::cmd_t  cmd,
	output lfsub_pkg::stat_t stat,
	output                   logic [63:0] random_value
);
	import lfsub_pkg::*;

	localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(LONG_LAG - 1);
	localparam logic [RING_AW-1:0] SHORT_R   = RING_AW'(SHORT_LAG);
	localparam logic [RING_AW-1:0] DIFF_R    = RING_AW'(LONG_LAG - SHORT_LAG);

	// Seed registers.
	logic [WORD_W-1:0] seed_lo;
	logic [WORD_W-1:0] ld_q;
	logic [WORD_W:0]   ld_dbl;
	logic [WORD_W-1:0] sq_q;

	assign seed_lo = (seed_value == 64'd0) ? ZERO_SEED : seed_value[WORD_W-1:0];
	assign ld_dbl  = {ld_q, 1'b0};

	always_ff @(posedge clk) begin
		if (cmd.seed_load) begin
			ld_q <= (seed_lo + WORD_W'(2)) & LADDER_MASK;
			sq_q <= seed_lo;
		end else begin
			if (cmd.ld_step) begin
				ld_q <= ld_dbl[WORD_W] ? WORD_W'(ld_dbl - LADDER_SUB) : ld_dbl[WORD_W-1:0];
			end
			if (cmd.sq_shift) begin
				sq_q <= sq_q >> 1;
			end
		end
	end

	// Scratch memory for the seeding rounds.
	logic [WORD_W-1:0] scr_mem [SCR_DEPTH];
	logic [WORD_W-1:0] sc_rdata_q;
	logic [WORD_W-1:0] hold_q;
	logic [WORD_W-1:0] sc_wdata;

	always_comb begin
		unique case (cmd.sc_wsel)
			WS_LADDER: sc_wdata = cmd.ld_odd ? (ld_q | WORD_W'(1)) : ld_q;
			WS_RDATA:  sc_wdata = sc_rdata_q;
			WS_ZERO:   sc_wdata = '0;
			WS_SUB:    sc_wdata = sc_rdata_q - hold_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.sc_we) begin
			scr_mem[cmd.sc_waddr] <= sc_wdata;
		end
		if (cmd.sc_re) begin
			sc_rdata_q <= scr_mem[cmd.sc_raddr];
		end
		if (cmd.hold_ld) begin
			hold_q <= sc_rdata_q;
		end
	end

	// Lag ring: circular memory, logical word k sits at (ptr + k) mod 100.
	logic [WORD_W-1:0]   ring_mem [LONG_LAG];
	logic [LONG_LAG-1:0] ring_vld_q;
	logic [RING_AW-1:0]  ptr_q;
	logic [RING_AW-1:0]  b_addr;
	logic [RING_AW:0]    ld_sum;
	logic [RING_AW-1:0]  ld_addr;
	logic [WORD_W-1:0]   ra_q, rb_q;
	logic                va_s1, vb_s1;
	logic                step_s1, copy_s1;
	logic [RING_AW-1:0]  waddr_s1, cidx_s1;
	logic [WORD_W-1:0]   a_word, b_word, diff;
	logic                ring_we;
	logic [RING_AW-1:0]  ring_wa;
	logic [WORD_W-1:0]   ring_wd;

	assign b_addr  = (ptr_q >= SHORT_R) ? (ptr_q - SHORT_R) : (ptr_q + DIFF_R);
	assign ld_sum  = {1'b0, ptr_q} + {1'b0, cmd.ring_lidx};
	assign ld_addr = (ld_sum >= (RING_AW + 1)'(LONG_LAG)) ?
	                 RING_AW'(ld_sum - (RING_AW + 1)'(LONG_LAG)) : ld_sum[RING_AW-1:0];

	// Never-written ring words read as zero.
	assign a_word = va_s1 ? ra_q : '0;
	assign b_word = vb_s1 ? rb_q : '0;
	assign diff   = a_word - b_word;

	assign ring_we = step_s1 | cmd.ring_ld_we;
	assign ring_wa = step_s1 ? waddr_s1 : ld_addr;
	assign ring_wd = step_s1 ? diff : sc_rdata_q;

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_wa] <= ring_wd;
		end
		if (cmd.ring_step) begin
			ra_q <= ring_mem[ptr_q];
			rb_q <= ring_mem[b_addr];
		end
		waddr_s1 <= ptr_q;
		cidx_s1  <= cmd.copy_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q <= '0;
			ptr_q      <= '0;
			step_s1    <= 1'b0;
			copy_s1    <= 1'b0;
			va_s1      <= 1'b0;
			vb_s1      <= 1'b0;
		end else begin
			if (ring_we) begin
				ring_vld_q[ring_wa] <= 1'b1;
			end
			step_s1 <= cmd.ring_step;
			copy_s1 <= cmd.ring_copy;
			if (cmd.ring_step) begin
				va_s1 <= ring_vld_q[ptr_q];
				vb_s1 <= ring_vld_q[b_addr];
				ptr_q <= (ptr_q == RING_LAST) ? '0 : ptr_q + 1'b1;
			end
		end
	end

	// Output batch and draw words.
	logic [WORD_W-1:0]  batch_mem [LONG_LAG];
	logic [WORD_W-1:0]  g_q [DRAW_WORDS];
	logic [RING_AW-1:0] rd_idx_q;

	always_ff @(posedge clk) begin
		if (copy_s1) begin
			batch_mem[cidx_s1] <= a_word;
		end
		if (cmd.batch_re) begin
			g_q[DRAW_WORDS-1] <= batch_mem[rd_idx_q];
			for (int i = 0; i < DRAW_WORDS - 1; i++) begin
				g_q[i] <= g_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
		end else if (cmd.rd_reset) begin
			rd_idx_q <= '0;
		end else if (cmd.batch_re) begin
			rd_idx_q <= (rd_idx_q == RING_LAST) ? '0 : rd_idx_q + 1'b1;
		end
	end

	// Combine four words and shift by the low word.
	logic [31:0] lo_word, hi_word;
	logic [63:0] comb_word;
	logic [63:0] out_q;

	assign lo_word   = {2'b00, g_q[0]} ^ {g_q[1], 2'b00};
	assign hi_word   = {2'b00, g_q[2]} ^ {g_q[3], 2'b00};
	assign comb_word = {hi_word, lo_word} >> lo_word[5:0];

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= comb_word;
		end
	end

	assign random_value = out_q;
	assign stat.rd_zero = (rd_idx_q == '0);
	assign stat.sq_zero = (sq_q == '0);
	assign stat.sq_lsb  = sq_q[0];

endmodule
`default_nettype wire

@@ rtl/lagged_fibonacci_subtractive_rng.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lagged_fibonacci_subtractive_rng
// Subtractive lagged Fibonacci generator, lags 100 and 37, modulo 2^30.
// ----------------------------------------------------------------------------
// A draw (mode 0) runs four batch reads and a result load when the
// current batch still has words; the load waits while an earlier result is
// untaken. Every 25th draw first regenerates the batch (one recurrence step
// per cycle through the two-read-port ring memory). A reseed (mode 1) gives
// no result. Its seeding rounds walk the 199-word scratch memory and are
// followed by 1990 ring warm-up steps. Input is accepted only while the
// sequencer is idle; a finished beat waits in the output register while the
// next item is taken.
module lagged_fibonacci_subtractive_rng #(
	parameter int BATCH_LENGTH = lfsub_pkg::BATCH_LEN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic        mode,
	input  wire logic [63:0] seed_value,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [63:0] random_value
);
	import lfsub_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	lfsub_ctrl #(
		.BATCH_LENGTH(BATCH_LENGTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.cmd       (cmd),
		.stat      (stat)
	);

	lfsub_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.seed_value   (seed_value),
		.cmd          (cmd),
		.stat         (stat),
		.random_value (random_value)
	);

	// A new result must never overwrite one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("result loaded over a pending beat");

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.out_load))
		else $error("output valid rose without a load");

	a_ring_port: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ring_step |-> !cmd.ring_ld_we)
		else $error("ring step and ring load issued together");

endmodule
`default_nettype wire

@@ tb/sv/tb_lagged_fibonacci_subtractive_rng.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lagged_fibonacci_subtractive_rng
// Drives draws and reseeds into the subtractive lagged Fibonacci generator and
// compares every random_value beat against an in-bench model of the ring,
// the batch regeneration and the full seeding procedure.
// ----------------------------------------------------------------------------
class lfsub_scoreboard;
	bit [29:0]  ring[lfsub_pkg::LONG_LAG];
	bit [29:0]  batch[lfsub_pkg::LONG_LAG];
	bit [29:0]  work[lfsub_pkg::BATCH_LEN_DEF];
	bit [29:0]  scratch[lfsub_pkg::SCR_DEPTH];
	int         rd_idx;
	bit [63:0]  expected_draws[$];
	int         errors;
	int         draws_checked;
	int         reseeds;

	function new();
		foreach (ring[i]) ring[i] = '0;
		rd_idx = 0;
	endfunction

	// Runs n recurrence steps into work; the ring then holds the next 100 words.
	function void run_lags(int n);
		int j;
		int k;
		for (j = 0; j < 100; j++) work[j] = ring[j];
		for (j = 100; j < n; j++) work[j] = work[j-100] - work[j-37];
		for (k = 0; k < 37; k++, j++) ring[k] = work[j-100] - work[j-37];
		for (; k < 100; k++, j++) ring[k] = work[j-100] - ring[k-37];
	endfunction

	function bit [29:0] next_word();
		bit [29:0] w;
		if (rd_idx == 0) begin
			run_lags(lfsub_pkg::BATCH_LEN_DEF);
			for (int i = 0; i < 100; i++) batch[i] = work[i];
		end
		w = batch[rd_idx];
		rd_idx = (rd_idx + 1) % 100;
		return w;
	endfunction

	function void reseed(bit [63:0] seed);
		bit [63:0] s;
		int        t;
		if (seed == 0) seed = 64'(lfsub_pkg::ZERO_SEED);
		s = (seed + 64'd2) & 64'h3FFFFFFE;
		for (int j = 0; j < 100; j++) begin
			scratch[j] = s[29:0];
			s = s << 1;
			if (s >= 64'h40000000) s = s - 64'h3FFFFFFE;
		end
		scratch[1] = scratch[1] + 30'd1;
		s = seed & 64'h3FFFFFFF;
		t = lfsub_pkg::SQ_ROUNDS;
		while (t != 0) begin
			for (int j = 99; j > 0; j--) begin
				scratch[j+j]   = scratch[j];
				scratch[j+j-1] = '0;
			end
			for (int j = 198; j >= 100; j--) begin
				scratch[j-63]  = scratch[j-63] - scratch[j];
				scratch[j-100] = scratch[j-100] - scratch[j];
			end
			if (s[0]) begin
				for (int j = 100; j > 0; j--) scratch[j] = scratch[j-1];
				scratch[0]  = scratch[100];
				scratch[37] = scratch[37] - scratch[100];
			end
			if (s != 0) s = s >> 1;
			else t--;
		end
		for (int j = 0; j < 37; j++) ring[j+63] = scratch[j];
		for (int j = 37; j < 100; j++) ring[j-37] = scratch[j];
		// Warm-up: ten passes of 199 steps; only the ring matters afterward.
		for (int j = 0; j < 10; j++) run_lags(lfsub_pkg::SCR_DEPTH);
		rd_idx = 0;
	endfunction

	function void note_input(bit mode, bit [63:0] seed);
		bit [31:0] lo;
		bit [31:0] hi;
		bit [63:0] q;
		if (mode) begin
			reseed(seed);
			reseeds++;
			return;
		end
		lo = 32'(next_word());
		lo = lo ^ (32'(next_word()) << 2);
		hi = 32'(next_word());
		hi = hi ^ (32'(next_word()) << 2);
		q = {hi, lo};
		expected_draws.push_back(q >> lo[5:0]);
	endfunction

	function void check_draw(bit [63:0] actual);
		bit [63:0] exp_val;
		if (expected_draws.size() == 0) begin
			$error("random_value beat with no draw pending: actual %h", actual);
			errors++;
			return;
		end
		exp_val = expected_draws.pop_front();
		draws_checked++;
		if (actual !== exp_val) begin
			$error("random_value mismatch: expected %h, actual %h", exp_val, actual);
			errors++;
		end
	endfunction
endclass

module tb_lagged_fibonacci_subtractive_rng;
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        mode;
	logic [63:0] seed_value;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] random_value;

	int              send_idle_pct;
	int              recv_idle_pct;
	lfsub_scoreboard rng_sb;

	lagged_fibonacci_subtractive_rng u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.seed_value  (seed_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.random_value(random_value)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
		if (out_valid && out_ready)
			rng_sb.check_draw(random_value);
	end

	// Valid is only lowered when a gap is taken, so back-to-back beats keep it high.
	task automatic send_item(input bit m, input bit [63:0] seed);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= m;
		seed_value <= seed;
		do @(posedge clk); while (!in_ready);
		rng_sb.note_input(m, seed);
	endtask

	task automatic drain_draws();
		in_valid <= 1'b0;
		@(posedge clk);
		while (rng_sb.expected_draws.size() != 0) @(posedge clk);
	endtask

	task automatic draw_burst(input int n);
		for (int i = 0; i < n; i++) send_item(1'b0, {$urandom, $urandom});
	endtask

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++) begin
			if (i == n / 2) begin
				// Let the block go idle, then reseed with a random seed.
				drain_draws();
				send_item(1'b1, ($urandom_range(3) == 0) ? 64'($urandom) :
					{$urandom, $urandom});
			end else begin
				send_item(1'b0, {$urandom, $urandom});
			end
		end
	endtask

	initial begin
		rng_sb        = new();
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		mode          = 1'b0;
		seed_value    = '0;
		out_ready     = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Draws from the zeroed ring, then after zero, all-ones and 0x4000_0001 seeds.
		draw_burst(3);
		send_item(1'b1, 64'd0);
		draw_burst(6);
		send_item(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
		draw_burst(6);
		send_item(1'b1, 64'h0000_0000_4000_0001);
		draw_burst(6);

		send_idle_pct = 6;
		recv_idle_pct = 80;
		random_phase(330);
		send_idle_pct = 80;
		recv_idle_pct = 6;
		random_phase(330);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(330);

		drain_draws();
		repeat (60) @(posedge clk);
		$display("Covered %0d reseeds and %0d checked draws, across three idle patterns.",
			rng_sb.reseeds, rng_sb.draws_checked);
		if (rng_sb.errors == 0 && rng_sb.expected_draws.size() == 0) begin
			$display("TB_OK");
		end else begin
			if (rng_sb.expected_draws.size() != 0)
				$error("%0d draws never returned", rng_sb.expected_draws.size());
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#12_000_000;
		$display("TB_ERROR");
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/lfsub_pkg.sv
rtl/lfsub_ctrl.sv
rtl/lfsub_dp.sv
rtl/lagged_fibonacci_subtractive_rng.sv
tb/sv/tb_lagged_fibonacci_subtractive_rng.sv
